FILE: rtl/core/apsp_pkg.sv
`timescale 1ns / 1ps
package apsp_pkg;

    localparam int CMD_W       = 2;
    localparam int VTX_W       = 7;
    localparam int EDGE_COST_W = 16;
    localparam int PATH_COST_W = 22;
    localparam int PRED_W      = 7;
    localparam int CFG_W       = 7;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

endpackage

FILE: rtl/core/apsp_cost_mem.sv
`timescale 1ns / 1ps
module apsp_cost_mem
    import apsp_pkg::*;
#(
    parameter int MAX_NODES = 64,
    parameter int COST_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_we,
    input  logic [2*$clog2(MAX_NODES)-1:0] i_waddr,
    input  logic [COST_BITS:0]          i_wdata,
    input  logic [2*$clog2(MAX_NODES)-1:0] i_raddr,
    output logic [COST_BITS:0]          o_rdata,
    output logic                        o_clearing
);

    localparam int IW    = $clog2(MAX_NODES);
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;

    logic [COST_BITS:0] r_mem [DEPTH];
    logic [COST_BITS:0] r_rdata;
    logic               r_clr;
    logic [AW-1:0]      r_clr_addr;

    logic               w_we;
    logic [AW-1:0]      w_addr;
    logic [COST_BITS:0] w_data;

    // sweep to no-edge after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == {AW{1'b1}}) begin
                r_clr <= 1'b0;
            end
        end
    end

    always_comb begin
        w_we   = r_clr | i_we;
        w_addr = r_clr ? r_clr_addr : i_waddr;
        w_data = r_clr ? '0 : i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata    = r_rdata;
    assign o_clearing = r_clr;

endmodule

FILE: rtl/core/apsp_engine.sv
`timescale 1ns / 1ps
module apsp_engine
    import apsp_pkg::*;
#(
    parameter int MAX_NODES = 64,
    parameter int COST_BITS = 16,
    parameter int DIST_BITS = 22
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [$clog2(MAX_NODES+1)-1:0]     i_n,
    output logic                               o_done,
    output logic [2*$clog2(MAX_NODES)-1:0]     o_cost_raddr,
    input  logic [COST_BITS:0]                 i_cost_rdata,
    input  logic [2*$clog2(MAX_NODES)-1:0]     i_rd_addr,
    output logic                               o_rd_reach,
    output logic [DIST_BITS-1:0]               o_rd_dist,
    output logic [$clog2(MAX_NODES+1)-1:0]     o_rd_pred
);

    localparam int IW    = $clog2(MAX_NODES);
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;
    localparam int NW    = $clog2(MAX_NODES + 1);
    localparam int PW    = NW;
    localparam int WW    = 1 + DIST_BITS + PW;
    localparam logic [DIST_BITS-1:0] DMAX = '1;

    typedef enum logic [2:0] {
        E_IDLE,
        E_INIT,
        E_FETCH,
        E_ROW,
        E_DRAIN
    } t_state;

    t_state            r_state;
    logic              r_done;
    logic [AW-1:0]     r_cnt;
    logic              r_iv;
    logic [AW-1:0]     r_iaddr;
    logic [IW-1:0]     r_k;
    logic [IW-1:0]     r_i;
    logic [IW-1:0]     r_j;
    logic              r_first;
    logic [WW-1:0]     r_dik;
    logic              r_pv;
    logic [IW-1:0]     r_pi;
    logic [IW-1:0]     r_pj;

    logic [WW-1:0]     r_mem [DEPTH];
    logic [WW-1:0]     r_ra;
    logic [WW-1:0]     r_rb;

    logic [IW-1:0]     w_last;
    logic [AW-1:0]     w_addr_a;
    logic [AW-1:0]     w_addr_b;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [WW-1:0]     w_wdata;

    logic [IW-1:0]     w_ii;
    logic [IW-1:0]     w_ij;
    logic              w_inr;
    logic [63:0]       w_cost64;
    logic [DIST_BITS-1:0] w_cost_sat;
    logic [WW-1:0]     w_init_word;

    logic              w_rik;
    logic              w_rkj;
    logic              w_rij;
    logic [DIST_BITS:0]   w_sum;
    logic [DIST_BITS-1:0] w_s;
    logic              w_relax;

    assign w_last = IW'(32'(i_n) - 32'd1);

    // init pass: word from the cost store
    always_comb begin
        w_ii       = r_iaddr[AW-1:IW];
        w_ij       = r_iaddr[IW-1:0];
        w_inr      = (32'(w_ii) < 32'(i_n)) && (32'(w_ij) < 32'(i_n));
        w_cost64   = 64'(i_cost_rdata[COST_BITS-1:0]);
        w_cost_sat = (w_cost64 > 64'(DMAX)) ? DMAX : DIST_BITS'(w_cost64);
        if (!w_inr) begin
            w_init_word = '0;
        end else if (w_ii == w_ij) begin
            w_init_word = {1'b1, {DIST_BITS{1'b0}}, PW'(32'(w_ii) + 32'd1)};
        end else if (i_cost_rdata[COST_BITS]) begin
            w_init_word = {1'b1, w_cost_sat, PW'(32'(w_ii) + 32'd1)};
        end else begin
            w_init_word = '0;
        end
    end

    // relaxation: r_ra = d[k][j], r_rb = d[i][j]
    always_comb begin
        w_rik   = r_dik[WW-1];
        w_rkj   = r_ra[WW-1];
        w_rij   = r_rb[WW-1];
        w_sum   = {1'b0, r_dik[WW-2:PW]} + {1'b0, r_ra[WW-2:PW]};
        w_s     = w_sum[DIST_BITS] ? DMAX : w_sum[DIST_BITS-1:0];
        w_relax = r_pv && w_rik && w_rkj && (!w_rij || (w_s < r_rb[WW-2:PW]));
    end

    always_comb begin
        if (r_iv) begin
            w_we    = 1'b1;
            w_waddr = r_iaddr;
            w_wdata = w_init_word;
        end else begin
            w_we    = w_relax;
            w_waddr = {r_pi, r_pj};
            w_wdata = {1'b1, w_s, r_ra[PW-1:0]};
        end
        w_addr_a = (r_state == E_ROW) ? {r_k, r_j} : {r_i, r_k};
        w_addr_b = (r_state == E_ROW) ? {r_i, r_j} : i_rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_ra <= r_mem[w_addr_a];
        r_rb <= r_mem[w_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_done  <= 1'b0;
            r_iv    <= 1'b0;
            r_pv    <= 1'b0;
            r_first <= 1'b0;
            r_cnt   <= '0;
            r_k     <= '0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_done  <= (r_state == E_DRAIN);
            r_iv    <= (r_state == E_INIT);
            r_iaddr <= r_cnt;
            r_pv    <= (r_state == E_ROW);
            r_pi    <= r_i;
            r_pj    <= r_j;
            case (r_state)
                E_IDLE: begin
                    r_cnt <= '0;
                    if (i_start) begin
                        r_state <= E_INIT;
                    end
                end
                E_INIT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == {AW{1'b1}}) begin
                        r_k     <= '0;
                        r_i     <= '0;
                        r_state <= E_FETCH;
                    end
                end
                E_FETCH: begin
                    r_j     <= '0;
                    r_first <= 1'b1;
                    r_state <= E_ROW;
                end
                E_ROW: begin
                    r_first <= 1'b0;
                    if (r_first) begin
                        r_dik <= r_ra;
                    end
                    r_j <= r_j + 1'b1;
                    if (r_j == w_last) begin
                        if (r_i == w_last) begin
                            r_i <= '0;
                            if (r_k == w_last) begin
                                r_state <= E_DRAIN;
                            end else begin
                                r_k     <= r_k + 1'b1;
                                r_state <= E_FETCH;
                            end
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= E_FETCH;
                        end
                    end
                end
                E_DRAIN: begin
                    r_state <= E_IDLE;
                end
                default: begin
                    r_state <= E_IDLE;
                end
            endcase
        end
    end

    assign o_done       = r_done;
    assign o_cost_raddr = r_cnt;
    assign o_rd_reach   = r_rb[WW-1];
    assign o_rd_dist    = r_rb[WW-2:PW];
    assign o_rd_pred    = r_rb[PW-1:0];

endmodule

FILE: rtl/core/all_pairs_shortest_path_unit.sv
`timescale 1ns / 1ps
// All-pairs shortest path unit (Floyd-Warshall with predecessors).
// Requests enter on s_axis: tuser is the command (write edge, run, read),
// tdata carries row, col, edge cost and edge-present flag. Every request
// yields one response on m_axis: tuser echoes the command, tdata carries
// path cost, predecessor and reachable flag (zero except on a hit read).
// Configuration: i_cfg_valid/o_cfg_ready/i_cfg_data set node_count (reset
// 64, clamped to 1..MAX_NODES); write it only while the unit is idle.
// Write and unused commands respond in the cycle after acceptance; a read
// passes through the dist-memory read register and then the response
// register. A run makes an init pass over every cost-store address, then
// for each k and each row one fetch of d[i][k], then one j per cycle
// through the dual-read dist memory.
// After reset every cost-memory entry is swept to no-edge, one entry per
// cycle; s_axis_tready is low meanwhile. One request is in flight at a
// time; the response sits in an output register, and a new request is
// taken while it is being taken by the receiver. A stalled receiver
// holds off new requests.
module all_pairs_shortest_path_unit
    import apsp_pkg::*;
#(
    parameter int MAX_NODES = 64,
    parameter int COST_BITS = 16,
    parameter int DIST_BITS = 22
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [6:0] row, [13:7] col, [29:14] edge_cost, [30] edge_present
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // cmd
    input  logic [CMD_W-1:0]       s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [21:0] path_cost, [28:22] predecessor, [29] reachable
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // ack_kind
    output logic [CMD_W-1:0]       m_axis_tuser,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    localparam int IW = $clog2(MAX_NODES);
    localparam int AW = 2 * IW;
    localparam int NW = $clog2(MAX_NODES + 1);
    localparam int EW = (COST_BITS > EDGE_COST_W) ? COST_BITS : EDGE_COST_W;

    typedef enum logic [1:0] {
        T_IDLE,
        T_READ,
        T_RUN
    } t_state;

    t_state                 r_state;
    logic [CFG_W-1:0]       r_node_count;
    logic                   r_results_valid;
    logic                   r_rd_ok;
    logic                   r_out_valid;
    logic [PATH_COST_W-1:0] r_path_cost;
    logic [PRED_W-1:0]      r_pred;
    logic                   r_reach;
    logic [CMD_W-1:0]       r_ack;
    logic                   n_out_valid;

    logic [VTX_W-1:0]       w_row;
    logic [VTX_W-1:0]       w_col;
    logic [EW-1:0]          w_cost_ext;
    logic                   w_present;
    logic [NW-1:0]          w_n;
    logic                   w_inrange;
    logic [IW-1:0]          w_row_idx;
    logic [IW-1:0]          w_col_idx;
    logic [AW-1:0]          w_addr;
    logic                   w_accept;
    logic                   w_start;
    logic                   w_cost_we;
    logic                   w_clearing;
    logic [COST_BITS:0]     w_cost_rdata;
    logic [AW-1:0]          w_cost_raddr;
    logic                   w_done;
    logic                   w_rd_reach;
    logic [DIST_BITS-1:0]   w_rd_dist;
    logic [NW-1:0]          w_rd_pred;
    logic [63:0]            w_dist64;
    logic [31:0]            w_pred32;

    always_comb begin
        w_row      = s_axis_tdata[6:0];
        w_col      = s_axis_tdata[13:7];
        w_cost_ext = EW'(s_axis_tdata[29:14]);
        w_present  = s_axis_tdata[30];
        if (r_node_count == '0) begin
            w_n = NW'(1);
        end else if (32'(r_node_count) > 32'(MAX_NODES)) begin
            w_n = NW'(MAX_NODES);
        end else begin
            w_n = NW'(r_node_count);
        end
        w_inrange = (w_row != '0) && (32'(w_row) <= 32'(w_n))
                 && (w_col != '0) && (32'(w_col) <= 32'(w_n));
        w_row_idx = IW'(32'(w_row) - 32'd1);
        w_col_idx = IW'(32'(w_col) - 32'd1);
        w_addr    = {w_row_idx, w_col_idx};
        w_accept  = s_axis_tvalid && s_axis_tready;
        w_start   = w_accept && (s_axis_tuser == CMD_RUN);
        w_cost_we = w_accept && (s_axis_tuser == CMD_WRITE) && w_inrange;
        w_dist64  = 64'(w_rd_dist);
        w_pred32  = 32'(w_rd_pred);
    end

    assign s_axis_tready = (r_state == T_IDLE) && !w_clearing
                        && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_out_valid = r_out_valid && !m_axis_tready;
        case (r_state)
            T_IDLE: begin
                if (w_accept && !(s_axis_tuser inside {CMD_RUN, CMD_READ})) begin
                    n_out_valid = 1'b1;
                end
            end
            T_READ: begin
                n_out_valid = 1'b1;
            end
            T_RUN: begin
                if (w_done) begin
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_out_valid = r_out_valid && !m_axis_tready;
            end
        endcase
    end

    apsp_cost_mem #(
        .MAX_NODES (MAX_NODES),
        .COST_BITS (COST_BITS)
    ) u_cost_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (w_cost_we),
        .i_waddr    (w_addr),
        .i_wdata    ({w_present, w_cost_ext[COST_BITS-1:0]}),
        .i_raddr    (w_cost_raddr),
        .o_rdata    (w_cost_rdata),
        .o_clearing (w_clearing)
    );

    apsp_engine #(
        .MAX_NODES (MAX_NODES),
        .COST_BITS (COST_BITS),
        .DIST_BITS (DIST_BITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start),
        .i_n          (w_n),
        .o_done       (w_done),
        .o_cost_raddr (w_cost_raddr),
        .i_cost_rdata (w_cost_rdata),
        .i_rd_addr    (w_addr),
        .o_rd_reach   (w_rd_reach),
        .o_rd_dist    (w_rd_dist),
        .o_rd_pred    (w_rd_pred)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= CFG_W'(64);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_node_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= T_IDLE;
            r_results_valid <= 1'b0;
            r_out_valid     <= 1'b0;
            r_rd_ok         <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            case (r_state)
                T_IDLE: begin
                    if (w_accept) begin
                        r_ack       <= s_axis_tuser;
                        r_path_cost <= '0;
                        r_pred      <= '0;
                        r_reach     <= 1'b0;
                        r_rd_ok     <= w_inrange && r_results_valid;
                        case (s_axis_tuser)
                            CMD_RUN:  r_state <= T_RUN;
                            CMD_READ: r_state <= T_READ;
                            default:  r_state <= T_IDLE;
                        endcase
                    end
                end
                T_READ: begin
                    if (r_rd_ok && w_rd_reach) begin
                        r_path_cost <= w_dist64[PATH_COST_W-1:0];
                        r_pred      <= w_pred32[PRED_W-1:0];
                        r_reach     <= 1'b1;
                    end
                    r_state <= T_IDLE;
                end
                T_RUN: begin
                    if (w_done) begin
                        r_results_valid <= 1'b1;
                        r_state         <= T_IDLE;
                    end
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_reach, r_pred, r_path_cost};
    assign m_axis_tuser  = r_ack;

endmodule
